FILE: src/frame_bitmap_allocator_defines.svh
// assertion macros for the frame bitmap allocator
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame bitmap allocator check failed");
`define FBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame bitmap allocator check failed");
`else
`define FBA_ASSERT_IMPL(label, ante, cons)
`define FBA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/fba_pkg.sv
`default_nettype none

package fba_pkg;

  localparam int ADDR_W = 27;
  localparam int FREE_W = 15;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_SET   = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_TEST  = 2'd2;
  localparam cmd_t CMD_FIND  = 2'd3;

  localparam int STATE_W = 3;

  localparam logic [STATE_W-1:0] S_CLR  = 3'd0;
  localparam logic [STATE_W-1:0] S_IDLE = 3'd1;
  localparam logic [STATE_W-1:0] S_READ = 3'd2;
  localparam logic [STATE_W-1:0] S_SCAN = 3'd3;
  localparam logic [STATE_W-1:0] S_RESP = 3'd4;

endpackage

`default_nettype wire

FILE: src/fba_ram.sv
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wa,
  input  wire logic [WIDTH-1:0] wd,
  input  wire logic [AW-1:0]    ra,
  output logic      [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

FILE: src/fba_lowclr.sv
`default_nettype none

module fba_lowclr #(
  parameter int WIDTH = 32,
  parameter int PW    = 5
) (
  input  wire logic [WIDTH-1:0] word,
  output logic                  any_clear,
  output logic      [PW-1:0]    pos
);

  // lowest clear bit wins
  always_comb begin
    pos = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = PW'(i);
      end
    end
  end

  assign any_clear = ~&word;

endmodule

`default_nettype wire

FILE: src/frame_bitmap_allocator.sv
// mark used, mark free and test: word read in READ, result registered in RESP, one item at a time
// find: reads bitmap words in turn, scanning from the lowest word that
//   may hold a free frame; the single bitmap memory read port sets the scan rate
// reset: a clearing sweep writes every bitmap word to zero, one word per cycle
//   (1024 words by default), and no transaction is accepted until it ends
`default_nettype none
`include "frame_bitmap_allocator_defines.svh"

module frame_bitmap_allocator #(
  parameter int PAGE_BYTES  = 4096,
  parameter int FRAME_COUNT = 32768,
  parameter int WORD_BITS   = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire fba_pkg::cmd_t               command,
  input  wire logic [fba_pkg::ADDR_W-1:0]  frame_address,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             bit_value,
  output logic      [fba_pkg::FREE_W-1:0]  free_frame,
  output logic                             found
);

  import fba_pkg::*;

  localparam int PB_LOG    = $clog2(PAGE_BYTES);
  localparam int FW        = ADDR_W - PB_LOG;
  localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HW        = $clog2(MAP_WORDS + 1);
  localparam int CW        = $clog2(FRAME_COUNT + 1);
  localparam int XW0       = (FW > CW) ? FW : CW;
  localparam int XW        = (XW0 > WIW + BIT_W) ? XW0 : WIW + BIT_W;

  localparam logic [XW-1:0]  FRAME_LIMIT = XW'(FRAME_COUNT);
  localparam logic [HW-1:0]  HINT_NONE   = HW'(MAP_WORDS);
  localparam logic [WIW-1:0] LAST_WORD   = WIW'(MAP_WORDS - 1);

  logic [STATE_W-1:0] state;
  logic [WIW-1:0]     clr_ptr;
  logic [HW-1:0]      hint;
  cmd_t               cmd_r;
  logic [BIT_W-1:0]   bit_sel;
  logic [WIW-1:0]     word_ptr;
  logic               res_bit;
  logic [FREE_W-1:0]  res_free;
  logic               res_found;

  logic               accept;
  logic [XW-1:0]      in_frame_x;
  logic               in_frame_ok;
  logic [WIW-1:0]     in_word;
  logic [BIT_W-1:0]   in_bit;

  logic               ram_we;
  logic [WIW-1:0]     ram_wa;
  logic [WORD_BITS-1:0] ram_wd;
  logic [WIW-1:0]     ram_ra;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] bit_mask;

  logic               lc_any;
  logic [BIT_W-1:0]   lc_pos;
  logic [XW-1:0]      cand_x;
  logic               scan_hit;
  logic               out_free;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign in_frame_x  = XW'(frame_address[ADDR_W-1:PB_LOG]);
  assign in_frame_ok = in_frame_x < FRAME_LIMIT;
  assign in_word     = in_frame_x[BIT_W +: WIW];
  assign in_bit      = in_frame_x[BIT_W-1:0];
  assign bit_mask    = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
  assign out_free    = !out_valid || out_ready;

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WIW)
  ) u_map (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (rdata)
  );

  fba_lowclr #(
    .WIDTH (WORD_BITS),
    .PW    (BIT_W)
  ) u_lowclr (
    .word      (rdata),
    .any_clear (lc_any),
    .pos       (lc_pos)
  );

  assign cand_x   = XW'({word_ptr, lc_pos});
  assign scan_hit = lc_any && (cand_x < FRAME_LIMIT);

  always_comb begin
    ram_we = 1'b0;
    ram_wa = word_ptr;
    ram_wd = '0;
    ram_ra = in_word;
    case (state)
      S_CLR: begin
        ram_we = 1'b1;
        ram_wa = clr_ptr;
      end
      S_IDLE: begin
        if (command == CMD_FIND) begin
          ram_ra = WIW'(hint);
        end
      end
      S_READ: begin
        if (cmd_r == CMD_SET) begin
          ram_we = 1'b1;
          ram_wd = rdata | bit_mask;
        end else if (cmd_r == CMD_CLEAR) begin
          ram_we = 1'b1;
          ram_wd = rdata & ~bit_mask;
        end
      end
      S_SCAN: begin
        ram_ra = word_ptr + 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_ptr   <= '0;
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= command;
            bit_sel   <= in_bit;
            res_bit   <= 1'b0;
            res_free  <= '0;
            res_found <= 1'b0;
            if (command == CMD_FIND) begin
              word_ptr <= WIW'(hint);
              if (hint == HINT_NONE) begin
                state <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end else if (in_frame_ok) begin
              word_ptr <= in_word;
              state    <= S_READ;
              // words below the hint are full, a free lowers it
              if ((command == CMD_CLEAR) && (HW'(in_word) < hint)) begin
                hint <= HW'(in_word);
              end
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_READ: begin
          if (cmd_r == CMD_TEST) begin
            res_bit <= rdata[bit_sel];
          end
          state <= S_RESP;
        end
        S_SCAN: begin
          if (scan_hit) begin
            res_found <= 1'b1;
            res_free  <= FREE_W'(cand_x);
            hint      <= HW'(word_ptr);
            state     <= S_RESP;
          end else if (word_ptr == LAST_WORD) begin
            hint  <= HINT_NONE;
            state <= S_RESP;
          end else begin
            word_ptr <= word_ptr + 1'b1;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            bit_value  <= res_bit;
            free_frame <= res_free;
            found      <= res_found;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FBA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  `FBA_ASSERT_IMPL(a_write_state, ram_we, (state == S_CLR) || (state == S_READ))
  `FBA_ASSERT_IMPL(a_out_fields, out_valid, !(found && bit_value))
  `FBA_ASSERT_IMPL(a_hint_range, state == S_SCAN, hint != HINT_NONE)

endmodule

`default_nettype wire
